FILE: rtl/lrp_pkg.sv
// ----------------------------------------------------------------------------
// lrp_pkg: shared definitions for the logistic regression predictor
// Sizes, item kinds and the queue entry that passes from front to back.
// ----------------------------------------------------------------------------
package lrp_pkg;

   // Feature limit and coefficient table.
   localparam int MAX_FEATURES = 16;
   localparam int TABLE_DEPTH  = 16;
   localparam int LIMIT        = (MAX_FEATURES < TABLE_DEPTH) ? MAX_FEATURES : TABLE_DEPTH;
   localparam int IDX_W        = (LIMIT > 1) ? $clog2(LIMIT) : 1;
   localparam int POS_W        = $clog2(LIMIT + 1);

   // Fixed-point formats.
   localparam int FRAC_BITS = 12;
   localparam int SLOT_W    = 4;
   localparam int VALUE_W   = 16;
   localparam int PROD_W    = 2 * VALUE_W;
   localparam int ACC_W     = 40;
   localparam int TOT_W     = ACC_W + 1;
   localparam int WS_W      = 32;
   localparam int PROB_W    = 16;

   // Stream payload widths.
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 48;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Kind of an input item, carried in tuser.
   typedef enum logic [0:0] {
      REQ_LOAD    = 1'b0,
      REQ_FEATURE = 1'b1
   } req_kind_type;

   // One feature on its way to the multiply-accumulate.
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic signed [VALUE_W-1:0] coef;
      logic                      acc_en;
      logic                      last;
      logic                      too_many;
   } q_entry_type;

   // Queue fill status seen by both sides.
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

FILE: rtl/lrp_front.sv
// ----------------------------------------------------------------------------
// lrp_front: input classification and coefficient table
// Loads coefficients, tracks the feature position and queues features.
// ----------------------------------------------------------------------------
module lrp_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [lrp_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tlast,
   input  logic [0:0]                     req_tuser,
   input  lrp_pkg::q_status_type          q_status,
   output logic                           q_push,
   output lrp_pkg::q_entry_type           q_entry
);
   import lrp_pkg::*;

   localparam logic [POS_W-1:0]  LIMIT_POS  = POS_W'(LIMIT);
   localparam logic [SLOT_W:0]   LIMIT_SLOT = (SLOT_W + 1)'(LIMIT);

   logic signed [VALUE_W-1:0] coef_table [LIMIT];
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic                      ovf_ff, ovf_in;
   logic                      accept;
   logic                      is_feature;
   logic                      in_range;
   logic [SLOT_W-1:0]         slot;
   logic signed [VALUE_W-1:0] value;

   // Field unpacking and acceptance.
   assign slot       = req_tdata[SLOT_W-1:0];
   assign value      = req_tdata[SLOT_W+VALUE_W-1:SLOT_W];
   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign is_feature = (req_tuser[0] == REQ_FEATURE);
   assign in_range   = (pos_ff < LIMIT_POS);

   // Coefficient loads; slots beyond the limit are dropped.
   always_ff @(posedge clock) begin
      if (accept && !is_feature && ({1'b0, slot} < LIMIT_SLOT)) begin
         coef_table[slot[IDX_W-1:0]] <= value;
      end
   end

   // Position counter and overflow flag; both restart after the last feature.
   always_comb begin
      pos_in = pos_ff;
      ovf_in = ovf_ff;
      if (accept && is_feature) begin
         if (req_tlast) begin
            pos_in = '0;
            ovf_in = 1'b0;
         end else if (in_range) begin
            pos_in = pos_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         ovf_ff <= ovf_in;
      end
   end

   // A feature goes to the back if it adds to the sum or closes the vector.
   assign q_push           = accept && is_feature && (in_range || req_tlast);
   assign q_entry.value    = value;
   assign q_entry.coef     = coef_table[pos_ff[IDX_W-1:0]];
   assign q_entry.acc_en   = in_range;
   assign q_entry.last     = req_tlast;
   assign q_entry.too_many = ovf_ff || !in_range;

endmodule

FILE: rtl/lrp_queue.sv
// ----------------------------------------------------------------------------
// lrp_queue: small FIFO between front and back
// Holds queued features so that either side can stall on its own.
// ----------------------------------------------------------------------------
module lrp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  lrp_pkg::q_entry_type  push_entry,
   input  logic                  pop,
   output lrp_pkg::q_entry_type  head,
   output lrp_pkg::q_status_type status
);
   import lrp_pkg::*;

   q_entry_type       entries [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries[wr_ptr_ff] <= push_entry;
      end
   end

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head         = entries[rd_ptr_ff];
   assign status.full  = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

FILE: rtl/lrp_back.sv
// ----------------------------------------------------------------------------
// lrp_back: multiply-accumulate, rounding and sigmoid
// Four-stage pipeline from queued feature to the registered result.
// ----------------------------------------------------------------------------
module lrp_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic signed [lrp_pkg::VALUE_W-1:0] intercept,
   input  lrp_pkg::q_entry_type           head,
   input  lrp_pkg::q_status_type          q_status,
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [lrp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [0:0]                     rsp_tuser
);
   import lrp_pkg::*;

   localparam logic [34:0] THR_FIVE = 35'(5) << FRAC_BITS;
   localparam logic [34:0] THR_MID  = 35'(19) << FRAC_BITS;
   localparam logic [34:0] THR_ONE  = 35'(1) << FRAC_BITS;

   // PLAN sigmoid: segments are taken on |z| and mirrored for negative z.
   function automatic logic [PROB_W-1:0] plan_sigmoid(input logic signed [WS_W-1:0] z);
      logic [WS_W-1:0]    mag;
      logic [WS_W+15:0]   wide;
      logic [WS_W+15:0]   seg;
      logic [PROB_W:0]    y;
      mag  = z[WS_W-1] ? (~z + 1'b1) : z;
      wide = {mag, 16'b0};
      if ({3'b000, mag} >= THR_FIVE) begin
         y = 17'd65536;
      end else if ({mag, 3'b000} >= THR_MID) begin
         seg = wide >> (FRAC_BITS + 5);
         y   = seg[PROB_W:0] + 17'd55296;
      end else if ({3'b000, mag} >= THR_ONE) begin
         seg = wide >> (FRAC_BITS + 3);
         y   = seg[PROB_W:0] + 17'd40960;
      end else begin
         seg = wide >> (FRAC_BITS + 2);
         y   = seg[PROB_W:0] + 17'd32768;
      end
      if (z[WS_W-1]) begin
         y = 17'd65536 - y;
      end
      return y[PROB_W] ? {PROB_W{1'b1}} : y[PROB_W-1:0];
   endfunction

   logic                      advance;

   logic                      s1_valid_ff;
   logic signed [PROD_W-1:0]  s1_prod_ff;
   logic                      s1_acc_en_ff;
   logic                      s1_last_ff;
   logic                      s1_too_many_ff;

   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [TOT_W-1:0]   acc_sum;
   logic signed [ACC_W-1:0]   acc_sat;

   logic                      s2_valid_ff, s2_valid_in;
   logic signed [ACC_W-1:0]   s2_sum_ff;
   logic                      s2_too_many_ff;

   logic signed [TOT_W-1:0]   total;
   logic signed [TOT_W-1:0]   shifted;
   logic signed [WS_W-1:0]    ws_in;
   logic                      s3_valid_ff;
   logic signed [WS_W-1:0]    s3_ws_ff;
   logic                      s3_too_many_ff;

   logic                      out_valid_ff;
   logic [PROB_W-1:0]         out_prob_ff;
   logic signed [WS_W-1:0]    out_ws_ff;
   logic                      out_too_many_ff;

   // The whole pipeline moves when the output register is free or being taken.
   assign advance = !out_valid_ff || rsp_tready;
   assign pop     = advance && !q_status.empty;

   // Stage 1: coefficient times feature.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= !q_status.empty;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_prod_ff     <= head.value * head.coef;
         s1_acc_en_ff   <= head.acc_en;
         s1_last_ff     <= head.last;
         s1_too_many_ff <= head.too_many;
      end
   end

   // Stage 2: saturating accumulate; the last feature hands the sum on.
   always_comb begin
      acc_sum = TOT_W'(acc_ff) + (s1_acc_en_ff ? TOT_W'(s1_prod_ff) : '0);
      if (acc_sum[TOT_W-1] != acc_sum[ACC_W-1]) begin
         acc_sat = acc_sum[TOT_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         acc_sat = acc_sum[ACC_W-1:0];
      end
      acc_in      = acc_ff;
      s2_valid_in = 1'b0;
      if (s1_valid_ff) begin
         acc_in      = s1_last_ff ? '0 : acc_sat;
         s2_valid_in = s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff      <= '0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         acc_ff      <= acc_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s2_valid_in) begin
         s2_sum_ff      <= acc_sat;
         s2_too_many_ff <= s1_too_many_ff;
      end
   end

   // Stage 3: add the intercept, floor to the output format and saturate.
   always_comb begin
      total   = TOT_W'(s2_sum_ff) + (TOT_W'(intercept) <<< FRAC_BITS);
      shifted = total >>> FRAC_BITS;
      if (shifted[TOT_W-1:WS_W-1] != {(TOT_W-WS_W+1){shifted[TOT_W-1]}}) begin
         ws_in = shifted[TOT_W-1] ? {1'b1, {(WS_W-1){1'b0}}} : {1'b0, {(WS_W-1){1'b1}}};
      end else begin
         ws_in = shifted[WS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s2_valid_ff) begin
         s3_ws_ff       <= ws_in;
         s3_too_many_ff <= s2_too_many_ff;
      end
   end

   // Stage 4: sigmoid into the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s3_valid_ff) begin
         out_prob_ff     <= plan_sigmoid(s3_ws_ff);
         out_ws_ff       <= s3_ws_ff;
         out_too_many_ff <= s3_too_many_ff;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = {out_ws_ff, out_prob_ff};
   assign rsp_tuser[0] = out_too_many_ff;

endmodule

FILE: rtl/logistic_regression_predictor.sv
// ----------------------------------------------------------------------------
// logistic_regression_predictor: fixed-point logistic regression inference
// Coefficient loads and features in, weighted sum and PLAN sigmoid out.
//
//   channel  direction  ports                         payload
//   req      in         req_tvalid/tready/tdata/      tdata: slot, value
//                       tlast/tuser                   tuser: item kind
//   rsp      out        rsp_tvalid/tready/tdata/      tdata: probability, sum
//                       tuser                         tuser: too_many
//   csr      in         csr_we/csr_wdata              intercept
//
// One item is accepted per cycle while the queue is not full; after the last
// feature of a vector is accepted, its result passes through the queue and the
// multiply, accumulate, rounding and sigmoid stages behind it.
// Reset clears the position counter, accumulator, queue and valid bits;
// coefficients stay undefined until loaded.
// A stalled result freezes the back pipeline; the front keeps taking items
// until the four-entry queue is full.
// ----------------------------------------------------------------------------
module logistic_regression_predictor (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [lrp_pkg::VALUE_W-1:0]    csr_wdata,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // tdata: [3:0] slot, [19:4] value, [23:20] zero
   input  logic [lrp_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tlast,
   // tuser: [0] req_type
   input  logic [0:0]                     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // tdata: [15:0] probability, [47:16] weighted_sum
   output logic [lrp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // tuser: [0] too_many
   output logic [0:0]                     rsp_tuser
);
   import lrp_pkg::*;

   logic signed [VALUE_W-1:0] intercept_ff;
   logic                      q_push;
   logic                      q_pop;
   q_entry_type               q_entry;
   q_entry_type               q_head;
   q_status_type              q_status;

   // Intercept register.
   always_ff @(posedge clock) begin
      if (reset) begin
         intercept_ff <= '0;
      end else if (csr_we) begin
         intercept_ff <= csr_wdata;
      end
   end

   lrp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   lrp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   lrp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .intercept  (intercept_ff),
      .head       (q_head),
      .q_status   (q_status),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // The queue is never both full and empty.
   assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue reports full and empty at once");

   // The front never pushes into a full queue.
   assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("push into full queue");

   // The back only pops a queue that holds an entry.
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("pop from empty queue");

   // A stalled result holds the back pipeline, so nothing leaves the queue.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !q_pop)
      else $error("queue popped while result stalled");

endmodule

FILE: test/logistic_regression_predictor_test.sv
// ----------------------------------------------------------------------------
// logistic_regression_predictor_test: self-checking bench for the predictor
// Loads coefficient tables, streams feature vectors under random back-pressure
// and compares every score with an in-bench fixed-point predictor of the
// multiply-accumulate, the intercept add and the PLAN sigmoid.
// ----------------------------------------------------------------------------
module logistic_regression_predictor_test;
   timeunit 1ns;
   timeprecision 1ps;

   import lrp_pkg::*;

   localparam int     STALL_LIMIT  = 2000;
   localparam int     DRAIN_CYCLES = 16;
   localparam int     PHASE_ITEMS  = 420;
   localparam int     REPORT_MAX   = 10;
   localparam longint ONE_Q16      = 65536;
   localparam longint PROB_MAX     = 65535;

   // One request on the input stream.
   typedef struct {
      req_kind_type              kind;
      logic [SLOT_W-1:0]         slot;
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } lr_item_type;

   // One score on the output stream.
   typedef struct {
      logic [PROB_W-1:0]      probability;
      logic signed [WS_W-1:0] weighted_sum;
      logic                   too_many;
   } score_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [VALUE_W-1:0]    csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // tdata: [3:0] slot, [19:4] value, [23:20] zero
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   // tuser: [0] req_type
   logic [0:0]            req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // tdata: [15:0] probability, [47:16] weighted_sum
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // tuser: [0] too_many
   logic [0:0]            rsp_tuser;

   // Stimulus and scoreboard storage.
   lr_item_type pending_items[$];
   score_type   scores_due[$];
   lr_item_type on_wire;
   int       mismatches = 0;
   int       send_gap   = 0;
   int       recv_stall = 0;
   int       quiet_cycles = 0;
   bit       send_idle  = 1'b1;
   bit       recv_idle  = 1'b1;

   // Predictor state: coefficient table, intercept and the running vector.
   logic signed [VALUE_W-1:0] coefs [TABLE_DEPTH];
   logic signed [VALUE_W-1:0] bias_q12 = '0;
   longint                    dot_acc  = 0;
   int                        feat_pos = 0;
   bit                        spilled  = 1'b0;

   logistic_regression_predictor uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // PLAN approximation of the sigmoid; segments act on |z| before the sign.
   function automatic logic [PROB_W-1:0] plan_prob(longint z);
      longint mag, y;
      mag = (z < 0) ? -z : z;
      if (mag >= (longint'(5) << FRAC_BITS)) begin
         y = ONE_Q16;
      end else if (mag * 8 >= (longint'(19) << FRAC_BITS)) begin
         y = ((mag << 16) >> (FRAC_BITS + 5)) + 55296;
      end else if (mag >= (longint'(1) << FRAC_BITS)) begin
         y = ((mag << 16) >> (FRAC_BITS + 3)) + 40960;
      end else begin
         y = ((mag << 16) >> (FRAC_BITS + 2)) + 32768;
      end
      if (y > ONE_Q16) y = ONE_Q16;
      if (z < 0) y = ONE_Q16 - y;
      if (y > PROB_MAX) y = PROB_MAX;
      return y[PROB_W-1:0];
   endfunction

   // Apply one accepted item to the predictor; a closing feature yields a score.
   function automatic void score_item(lr_item_type it);
      longint acc_max, total, ws;
      score_type s;
      acc_max = (longint'(1) << (ACC_W - 1)) - 1;
      if (it.kind == REQ_LOAD) begin
         if (it.slot < LIMIT) coefs[it.slot] = it.value;
         return;
      end
      if (feat_pos < LIMIT) begin
         dot_acc += longint'(it.value) * longint'(coefs[feat_pos]);
         if (dot_acc > acc_max) dot_acc = acc_max;
         if (dot_acc < -acc_max - 1) dot_acc = -acc_max - 1;
         feat_pos++;
      end else begin
         spilled = 1'b1;
      end
      if (!it.last) return;
      // Intercept is aligned to the product scale, then the sum is floored.
      total = dot_acc + (longint'(bias_q12) <<< FRAC_BITS);
      ws = total >>> FRAC_BITS;
      if (ws > longint'(32'sh7fffffff)) ws = longint'(32'sh7fffffff);
      if (ws < -longint'(32'sh7fffffff) - 1) ws = -longint'(32'sh7fffffff) - 1;
      s.probability  = plan_prob(ws);
      s.weighted_sum = ws[WS_W-1:0];
      s.too_many     = spilled;
      scores_due.insert(scores_due.size(), s);
      dot_acc  = 0;
      feat_pos = 0;
      spilled  = 1'b0;
   endfunction

   function automatic void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("[%0t] mismatch: %s", $time, msg);
   endfunction

   // Idle length: mostly none, some short, a few long.
   function automatic int draw_gap(bit enabled);
      int r;
      if (!enabled) return 0;
      r = $urandom_range(99);
      if (r < 70) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Value spread: full range, about +-1.0, about +-0.125, or an extreme.
   function automatic logic signed [VALUE_W-1:0] pick_value(int spread);
      case (spread)
         0: return VALUE_W'($urandom);
         1: return VALUE_W'(int'($urandom_range(8192)) - 4096);
         2: return VALUE_W'(int'($urandom_range(1024)) - 512);
         default: begin
            case ($urandom_range(4))
               0: return 16'sh8000;
               1: return 16'sh7fff;
               2: return 16'sh0000;
               3: return 16'sh0001;
               default: return 16'shffff;
            endcase
         end
      endcase
   endfunction

   function automatic void push_item(req_kind_type kind, int slot,
                                     logic signed [VALUE_W-1:0] value, bit last);
      lr_item_type it;
      it.kind  = kind;
      it.slot  = SLOT_W'(slot);
      it.value = value;
      it.last  = last;
      pending_items.insert(pending_items.size(), it);
   endfunction

   // Intercept write; only issued while nothing is in flight.
   task automatic set_bias(logic signed [VALUE_W-1:0] v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we   <= 1'b0;
      bias_q12 = v;
   endtask

   // Wait until every item is sent and every score has arrived, then let the
   // pipeline settle in case trailing loads are still moving through it.
   task automatic wait_idle();
      while (pending_items.size() != 0 || req_tvalid || scores_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Mostly well-formed vectors with random content, some coefficient reloads,
   // stray loads inside vectors and vectors longer than the table.
   task automatic random_phase(int n);
      int  sent, len, spread, r;
      bit  first;
      sent  = 0;
      first = 1'b1;
      while (sent < n) begin
         if (!first && $urandom_range(99) < 15) begin
            repeat ($urandom_range(1, 4)) begin
               r = $urandom_range(9);
               push_item(REQ_LOAD, $urandom_range(TABLE_DEPTH - 1),
                         pick_value(r == 0 ? 0 : (r == 1 ? 3 : 1)),
                         1'($urandom_range(1)));
               sent++;
            end
         end else begin
            if (first || $urandom_range(99) < 10) len = LIMIT + $urandom_range(1, 4);
            else len = $urandom_range(1, LIMIT);
            r = $urandom_range(9);
            spread = (r < 2) ? 0 : (r < 5) ? 1 : (r < 9) ? 2 : 3;
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(99) < 4) begin
                  push_item(REQ_LOAD, $urandom_range(TABLE_DEPTH - 1), pick_value(1),
                            1'($urandom_range(1)));
                  sent++;
               end
               push_item(REQ_FEATURE, $urandom_range(TABLE_DEPTH - 1), pick_value(spread),
                         i == len - 1);
               sent++;
            end
            first = 1'b0;
         end
      end
   endtask

   // Driver: presents queued items and feeds the predictor on each handshake.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) score_item(on_wire);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               on_wire = pending_items.pop_front();
               req_tdata  <= {{(REQ_DATA_W - SLOT_W - VALUE_W){1'b0}}, on_wire.value,
                              on_wire.slot};
               req_tlast  <= on_wire.last;
               req_tuser  <= on_wire.kind;
               req_tvalid <= 1'b1;
               send_gap = draw_gap(send_idle);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each score against the oldest prediction.
   always @(posedge clock) begin
      score_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.probability  = rsp_tdata[PROB_W-1:0];
            got.weighted_sum = rsp_tdata[PROB_W +: WS_W];
            got.too_many     = rsp_tuser[0];
            if (scores_due.size() == 0) begin
               note_mismatch($sformatf("score with none expected: prob %0d sum %0d flag %0b",
                                       got.probability, got.weighted_sum, got.too_many));
            end else begin
               want = scores_due.pop_front();
               if (got.probability !== want.probability)
                  note_mismatch($sformatf("probability expected %0d, got %0d",
                                          want.probability, got.probability));
               if (got.weighted_sum !== want.weighted_sum)
                  note_mismatch($sformatf("weighted_sum expected %0d, got %0d",
                                          want.weighted_sum, got.weighted_sum));
               if (got.too_many !== want.too_many)
                  note_mismatch($sformatf("too_many expected %0b, got %0b",
                                          want.too_many, got.too_many));
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            recv_stall = draw_gap(recv_idle);
         end
      end
   end

   // Watchdog: ends the run when no item moves for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("logistic_regression_predictor verification failed");
            $finish;
         end
      end
   end

   // Test sequence: directed table load and sigmoid edges, then random phases.
   initial begin : stimulus
      logic signed [VALUE_W-1:0] seed_coefs [TABLE_DEPTH];
      logic signed [VALUE_W-1:0] edge_features [8];
      seed_coefs = '{16'sd4096, 16'sh8000, 16'sd32767, -16'sd1, 16'sd1, 16'sd0,
                     16'sd2048, -16'sd4096, 16'sd1024, -16'sd2048, 16'sd256, -16'sd512,
                     16'sd3000, -16'sd100, 16'sd8192, -16'sd8192};
      // Slot 0 holds 1.0, so a one-feature vector gives z equal to the feature.
      edge_features = '{16'sd20480, 16'sd20479, 16'sd9728, 16'sd4096, 16'sd4095,
                        16'sd0, -16'sd1, 16'sh8000};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: fill the table, then hit each sigmoid segment edge.
      set_bias(16'sd0);
      for (int s = 0; s < TABLE_DEPTH; s++)
         push_item(REQ_LOAD, s, seed_coefs[s], 1'b0);
      foreach (edge_features[i])
         push_item(REQ_FEATURE, $urandom_range(TABLE_DEPTH - 1), edge_features[i], 1'b1);
      wait_idle();

      // Random phases: intercept extremes and random values, idling varied.
      for (int p = 0; p < 4; p++) begin
         send_idle = (p == 0 || p == 2);
         recv_idle = (p == 0 || p == 1);
         case (p)
            0: set_bias(16'sh8000);
            1: set_bias(16'sh7fff);
            2: set_bias(VALUE_W'($urandom));
            default: set_bias(VALUE_W'(int'($urandom_range(8192)) - 4096));
         endcase
         random_phase(PHASE_ITEMS);
         wait_idle();
      end

      if (mismatches == 0 && scores_due.size() == 0) begin
         $display("logistic_regression_predictor verification clean");
      end else begin
         $display("logistic_regression_predictor verification failed");
      end
      $finish;
   end

endmodule
